// File: hdl/session_table_with_login_quota_top_assert.svh
// ---------------------------------------------------------------------------
// Session table assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ---------------------------------------------------------------------------
`ifndef SESSION_TABLE_WITH_LOGIN_QUOTA_TOP_ASSERT_SVH
`define SESSION_TABLE_WITH_LOGIN_QUOTA_TOP_ASSERT_SVH

// same-cycle implication
`define STQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stq assertion failed");

// next-cycle implication
`define STQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stq assertion failed");

`endif

// File: hdl/stq_pkg.sv
// ---------------------------------------------------------------------------
// Session table package
// Shared widths, codes, entry layout and controller/datapath bundles.
// ---------------------------------------------------------------------------
package stq_pkg;

    localparam int CONN_W     = 16;
    localparam int KEY_W      = 48;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 4;
    localparam int QUOTA_W    = 5;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [QUOTA_W-1:0] QUOTA_RST = 5'd4;

    localparam logic REG_LOGIN_QUOTA = 1'b0;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CLOSE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACCT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HAND = 2'd2;

    localparam logic [STATUS_W-1:0] ST_REFRESH = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLOSED  = 2'd3;

    // conn in the low bits, matching the input word layout
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic              cloud;
        logic [CONN_W-1:0] conn;
    } t_entry;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic last_issued;
        logic out_free;
    } t_sts;

endpackage

// File: hdl/session_table_with_login_quota_top.sv
// ---------------------------------------------------------------------------
// Session table with login quota
// Add, refresh and close client sessions against a login quota.
// ---------------------------------------------------------------------------
// channel   direction  handshake          payload
// s         in         tvalid/tready      tuser func, tdata request word
// m         out        tvalid/tready      tuser status, tdata slot/evicted
// apb       in         psel/penable       login_quota at byte address 0
//
// Each request runs accept, one entry RAM read per cycle across the table,
// a drain state, then commit; the next request is accepted after commit.
// Commit waits while the output word is still held and not taken.
// Synchronous active-low reset clears valid bits; no clearing pass needed.
// ---------------------------------------------------------------------------
module session_table_with_login_quota_top
    import stq_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // conn_id[15:0], is_cloud[16], cloud_id[64:17], login_mode[66:65], zeros
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // func
    input  logic                  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // slot[3:0], evicted[4], zeros
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    // status
    output logic [STATUS_W-1:0]   o_m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [QUOTA_W-1:0] r_login_quota;
    t_cmd               w_cmd;
    t_sts               w_sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_login_quota <= QUOTA_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LOGIN_QUOTA)) begin
            r_login_quota <= pwdata[QUOTA_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_LOGIN_QUOTA) ? APB_DATA_W'(r_login_quota) : '0;

    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_sts      (w_sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    stq_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_login_quota (r_login_quota),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

endmodule

// File: hdl/stq_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/stq_ctrl.sv
// ---------------------------------------------------------------------------
// Session table controller
// Sequences accept, table scan, drain and commit of one request.
// ---------------------------------------------------------------------------
module stq_ctrl
    import stq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    input  t_sts i_sts,
    output logic o_s_tready,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_rdy, n_rdy;

    always_comb begin
        o_cmd.start  = (r_state == S_IDLE) && r_rdy && i_s_tvalid;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_COMMIT) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && r_rdy) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.last_issued) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_rdy = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rdy   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rdy   <= n_rdy;
        end
    end

    assign o_s_tready = r_rdy;

endmodule

// File: hdl/stq_dp.sv
// ---------------------------------------------------------------------------
// Session table datapath
// Entry RAM, valid bits, scan accumulators, decision and output register.
// ---------------------------------------------------------------------------
module stq_dp
    import stq_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    input  logic [QUOTA_W-1:0]   i_login_quota,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [STATUS_W-1:0]  o_m_tuser
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > QUOTA_W) ? CNT_W : QUOTA_W;
    localparam int ENT_W = $bits(t_entry);

    // request
    logic   r_func;
    t_entry r_req;

    // scan
    logic [IDX_W-1:0] r_addr;
    logic             r_pend;
    logic [IDX_W-1:0] r_pidx;
    logic [ENT_W-1:0] w_rdata;
    t_entry           w_ent;
    logic             w_ev;
    logic             w_match;

    // accumulators
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    t_entry           r_hit_ent;
    logic [CNT_W-1:0] r_cnt;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;
    logic             r_nom;
    logic [IDX_W-1:0] r_nom_idx;

    logic [ENTRIES-1:0] r_valid;
    logic               w_clr;

    // decision
    logic [CNT_W-1:0]        w_other;
    logic                    w_over_all;
    logic                    w_over_other;
    logic [STATUS_W-1:0]     w_status;
    logic [IDX_W-1:0]        w_widx;
    logic [IDX_W-1:0]        w_slot_idx;
    logic [IDX_W+SLOT_W-1:0] w_slot_ext;
    logic                    w_evict;
    logic                    w_we;
    logic                    w_place;
    t_entry                  w_wdata;

    // output word
    logic                r_m_valid;
    logic [STATUS_W-1:0] r_status;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_evict;

    stq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && w_we),
        .i_waddr (w_widx),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.scan),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_ent   = t_entry'(w_rdata);
    assign w_ev    = r_valid[r_pidx];
    assign w_match = r_req.cloud ? (w_ent.key == r_req.key) : (w_ent.conn == r_req.conn);
    assign w_clr   = r_pend && (r_func == FUNC_CLOSE) && w_ev && (w_ent.conn == r_req.conn);

    assign o_sts.last_issued = i_cmd.scan && (r_addr == IDX_W'(ENTRIES - 1));
    assign o_sts.out_free    = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func <= i_s_tuser;
            r_req  <= t_entry'(i_s_tdata[ENT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_cmd.scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_addr <= '0;
        end else if (i_cmd.scan) begin
            r_addr <= r_addr + 1'b1;
        end
        r_pidx <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hit  <= 1'b0;
            r_cnt  <= '0;
            r_free <= 1'b0;
            r_nom  <= 1'b0;
        end else if (r_pend) begin
            if (w_ev && w_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_pidx;
                r_hit_ent <= w_ent;
            end
            if (w_ev && (w_ent.mode == MODE_ACCT)) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (!w_ev && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_pidx;
            end
            if (w_ev && (w_ent.mode == MODE_NONE) && !r_nom) begin
                r_nom     <= 1'b1;
                r_nom_idx <= r_pidx;
            end
        end
    end

    assign w_other      = r_cnt - CNT_W'(r_hit_ent.mode == MODE_ACCT);
    assign w_over_all   = CMP_W'(r_cnt) >= CMP_W'(i_login_quota);
    assign w_over_other = CMP_W'(w_other) >= CMP_W'(i_login_quota);

    always_comb begin
        w_status   = ST_REFUSED;
        w_widx     = r_hit_idx;
        w_slot_idx = '0;
        w_evict    = 1'b0;
        w_we       = 1'b0;
        w_place    = 1'b0;
        w_wdata    = r_req;
        if (r_func == FUNC_CLOSE) begin
            w_status = ST_CLOSED;
        end else if (r_hit) begin
            if (!((r_req.mode == MODE_ACCT) && w_over_other)) begin
                w_status   = ST_REFRESH;
                w_slot_idx = r_hit_idx;
                w_we       = 1'b1;
                w_wdata    = r_hit_ent;
                if ((r_req.mode == MODE_ACCT) || (r_req.mode == MODE_HAND)) begin
                    w_wdata.mode = r_req.mode;
                end
            end
        end else if ((r_req.mode == MODE_ACCT) && w_over_all) begin
            w_status = ST_REFUSED;
        end else if (r_free) begin
            w_status   = ST_PLACED;
            w_widx     = r_free_idx;
            w_slot_idx = r_free_idx;
            w_we       = 1'b1;
            w_place    = 1'b1;
        end else if ((r_req.mode != MODE_NONE) && r_nom) begin
            w_status   = ST_PLACED;
            w_widx     = r_nom_idx;
            w_slot_idx = r_nom_idx;
            w_evict    = 1'b1;
            w_we       = 1'b1;
            w_place    = 1'b1;
        end
    end

    assign w_slot_ext = {{SLOT_W{1'b0}}, w_slot_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_clr) begin
                r_valid[r_pidx] <= 1'b0;
            end
            if (i_cmd.commit && w_place) begin
                r_valid[w_widx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= w_status;
            r_slot   <= w_slot_ext[SLOT_W-1:0];
            r_evict  <= w_evict;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = M_TDATA_W'({r_evict, r_slot});
    assign o_m_tuser  = r_status;

endmodule

// File: hdl/stq_checker.sv
// ---------------------------------------------------------------------------
// Session table port checker
// Port-level properties of the session table, bound to the top level.
// ---------------------------------------------------------------------------
`include "session_table_with_login_quota_top_assert.svh"

module stq_checker
    import stq_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [M_TDATA_W-1:0]  o_m_tdata,
    input logic [STATUS_W-1:0]   o_m_tuser,
    input logic                  pready
);

    // one request in flight: busy right after an accept
    `STQ_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    `STQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    `STQ_ASSERT_NOW(a_slot_zero, i_clk, i_rst_n,
        o_m_tvalid && ((o_m_tuser == ST_REFUSED) || (o_m_tuser == ST_CLOSED)),
        o_m_tdata[SLOT_W-1:0] == '0)

    `STQ_ASSERT_NOW(a_evict_placed, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tuser != ST_PLACED), !o_m_tdata[SLOT_W])

    `STQ_ASSERT_NOW(a_pready_high, i_clk, i_rst_n, 1'b1, pready)

endmodule

bind session_table_with_login_quota_top stq_checker u_stq_checker (.*);
